// ===== design/lz78c_pkg.sv =====
// lz78c_pkg: shared types and constants for the lz78 byte compressor
// no dependencies; used by every module of the block

package lz78c_pkg;

    localparam int INDEX_BITS = 8;
    localparam int DICT_SIZE  = (1 << INDEX_BITS) - 1;
    localparam int SYM_W      = 8;
    localparam int FIELD_W    = 8;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [SYM_W-1:0]      sym_t;

    typedef struct packed {
        sym_t symbol;
        logic last;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] prefix_index;
        sym_t               new_symbol;
        logic               stream_end;
    } out_item_t;

    typedef struct packed {
        index_t parent;
        sym_t   symbol;
    } entry_t;

    typedef struct packed {
        logic   hit;
        index_t pos;
    } match_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_MATCH   = 3'b010,
        S_RESOLVE = 3'b100
    } state_t;

endpackage

// ===== design/lz78c_cell.sv =====
// lz78c_cell: one dictionary entry with its own pair compare
// depends on lz78c_pkg; entries shift in from the left neighbor

module lz78c_cell (
    input  logic            clk,
    input  logic            shift,
    input  logic            live,
    input  lz78c_pkg::entry_t key,
    input  lz78c_pkg::entry_t entry_in,
    output lz78c_pkg::entry_t entry_out,
    output logic            hit
);

    lz78c_pkg::entry_t entry_reg;
    logic              hit_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= entry_in;
        end
        hit_reg <= live && (entry_reg == key);
    end

    assign entry_out = entry_reg;
    assign hit       = hit_reg;

endmodule

// ===== design/lz78c_cell_row.sv =====
// lz78c_cell_row: shifting row of dictionary cells and the hit position encoder
// depends on lz78c_pkg and lz78c_cell

module lz78c_cell_row (
    input  logic                                clk,
    input  logic                                shift,
    input  lz78c_pkg::index_t                   count,
    input  lz78c_pkg::entry_t                   key,
    input  lz78c_pkg::entry_t                   new_entry,
    output lz78c_pkg::match_t                   match,
    output logic [lz78c_pkg::DICT_SIZE-1:0]     hits
);

    lz78c_pkg::entry_t chain [lz78c_pkg::DICT_SIZE+1];
    logic [lz78c_pkg::DICT_SIZE-1:0] live;

    assign chain[0] = new_entry;

    for (genvar j = 0; j < lz78c_pkg::DICT_SIZE; j++)
    begin : g_cell
        assign live[j] = lz78c_pkg::INDEX_BITS'(j) < count;

        lz78c_cell u_cell (
            .clk       (clk),
            .shift     (shift),
            .live      (live[j]),
            .key       (key),
            .entry_in  (chain[j]),
            .entry_out (chain[j+1]),
            .hit       (hits[j])
        );
    end

    // at most one cell hits, so the position is a plain or of the hit slots
    always_comb
    begin
        match.hit = |hits;
        match.pos = '0;
        for (int j = 0; j < lz78c_pkg::DICT_SIZE; j++)
        begin
            match.pos = match.pos | (hits[j] ? lz78c_pkg::INDEX_BITS'(j) : '0);
        end
    end

endmodule

// ===== design/lz78c_top_ctrl.sv =====
// lz78c_top_ctrl: item sequencer, prefix and entry count, output register
// depends on lz78c_pkg; drives the shift and key of the cell row

module lz78c_top_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sym_valid,
    output logic                  sym_ready,
    input  lz78c_pkg::in_item_t   sym_data,
    output logic                  pair_valid,
    input  logic                  pair_ready,
    output lz78c_pkg::out_item_t  pair_data,
    input  lz78c_pkg::match_t     match,
    output logic                  shift,
    output lz78c_pkg::index_t     count,
    output lz78c_pkg::entry_t     key,
    output lz78c_pkg::state_t     state,
    output logic                  finish
);

    lz78c_pkg::state_t    state_reg, state_next;
    lz78c_pkg::in_item_t  item_reg;
    lz78c_pkg::index_t    prefix_reg, prefix_next;
    lz78c_pkg::index_t    count_reg, count_next;
    lz78c_pkg::out_item_t out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 emit;
    logic                 done;
    logic                 take;
    lz78c_pkg::index_t    hit_index;

    assign key       = '{parent: prefix_reg, symbol: item_reg.symbol};
    assign hit_index = count_reg - match.pos;
    assign emit      = !match.hit || item_reg.last;
    assign done      = (state_reg == lz78c_pkg::S_RESOLVE)
                       && (!emit || !out_valid_reg || pair_ready);
    assign sym_ready = (state_reg == lz78c_pkg::S_IDLE) || done;
    assign take      = sym_valid && sym_ready;
    assign shift     = done && !match.hit
                       && (count_reg != lz78c_pkg::INDEX_BITS'(lz78c_pkg::DICT_SIZE));

    always_comb
    begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !pair_ready;
        unique case (state_reg)
            lz78c_pkg::S_IDLE:
            begin
                if (take)
                begin
                    state_next = lz78c_pkg::S_MATCH;
                end
            end
            lz78c_pkg::S_MATCH:
            begin
                state_next = lz78c_pkg::S_RESOLVE;
            end
            lz78c_pkg::S_RESOLVE:
            begin
                if (done)
                begin
                    state_next  = take ? lz78c_pkg::S_MATCH : lz78c_pkg::S_IDLE;
                    prefix_next = (match.hit && !item_reg.last) ? hit_index : '0;
                    if (item_reg.last)
                    begin
                        count_next = '0;
                    end
                    else if (shift)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = lz78c_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lz78c_pkg::S_IDLE;
            prefix_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= sym_data;
        end
        if (done && emit)
        begin
            out_reg.prefix_index <= lz78c_pkg::FIELD_W'(prefix_reg);
            out_reg.new_symbol   <= item_reg.symbol;
            out_reg.stream_end   <= item_reg.last;
        end
    end

    assign pair_valid = out_valid_reg;
    assign pair_data  = out_reg;
    assign count      = count_reg;
    assign state      = state_reg;
    assign finish     = done && item_reg.last;

endmodule

// ===== design/lz78_byte_compressor_core.sv =====
// lz78_byte_compressor_core: top level of the lz78 byte compressor
// depends on lz78c_pkg, lz78c_top_ctrl and lz78c_cell_row
//
// Each byte passes through S_MATCH, in which every dictionary cell compares the
// pair (current prefix, byte) against its entry and registers a hit flag, and
// then S_RESOLVE, in which the hit position is encoded, the prefix and entry
// count move on, and a pair is loaded into the output register. The next byte
// is taken in S_RESOLVE, so a new byte is accepted while the current one
// resolves as long as the output register has room; a pending pair that is not
// taken holds the block. The dictionary is a row of 255 cells into which new
// entries shift from the left, so the newest entry sits in the first cell. It
// empties at each stream end by clearing the entry count, with no clearing pass.

module lz78_byte_compressor_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sym_valid,
    output logic                  sym_ready,
    input  lz78c_pkg::in_item_t   sym_data,
    output logic                  pair_valid,
    input  logic                  pair_ready,
    output lz78c_pkg::out_item_t  pair_data
);

    lz78c_pkg::match_t               match;
    logic                            shift;
    lz78c_pkg::index_t               count;
    lz78c_pkg::entry_t               key;
    lz78c_pkg::state_t               state;
    logic                            finish;
    logic [lz78c_pkg::DICT_SIZE-1:0] hits;

    lz78c_top_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .sym_data   (sym_data),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair_data  (pair_data),
        .match      (match),
        .shift      (shift),
        .count      (count),
        .key        (key),
        .state      (state),
        .finish     (finish)
    );

    lz78c_cell_row u_row (
        .clk       (clk),
        .shift     (shift),
        .count     (count),
        .key       (key),
        .new_entry (key),
        .match     (match),
        .hits      (hits)
    );

    // pairs are unique within a stream
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state == lz78c_pkg::S_RESOLVE |-> $onehot0(hits))
        else $error("more than one dictionary cell hit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> count != lz78c_pkg::INDEX_BITS'(lz78c_pkg::DICT_SIZE))
        else $error("entry written into a full dictionary");

    a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> count == '0 && key.parent == '0)
        else $error("dictionary not cleared at end of stream");

    a_no_take_in_match: assert property (@(posedge clk) disable iff (!rst_n)
        state == lz78c_pkg::S_MATCH |-> !sym_ready && !shift)
        else $error("transfer or entry write during compare cycle");

endmodule

// ===== bench/tb_lz78_byte_compressor_core.sv =====
`timescale 1ns / 100ps
// tb_lz78_byte_compressor_core: self-checking bench for the lz78 byte compressor
// depends on lz78c_pkg and lz78_byte_compressor_core; keeps its own dictionary
// to predict every pair but those of typed rows, over a short directed table and random byte streams

module tb_lz78_byte_compressor_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_BYTES    = 215;
    localparam int MAX_REPORTS    = 30;
    localparam int N_DIRECTED     = 20;

    typedef struct packed {
        lz78c_pkg::sym_t              symbol;
        logic                         last;
        logic                         typed;
        logic                         has_pair;
        logic [lz78c_pkg::FIELD_W-1:0] exp_prefix;
        lz78c_pkg::sym_t              exp_symbol;
        logic                         exp_end;
    } vector_t;

    // typed rows carry their pair, the rest go through the dictionary model
    vector_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 8'h01, 8'hFF, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b1, 8'h02, 8'h80, 1'b1},
        '{8'h55, 1'b1, 1'b1, 1'b1, 8'h00, 8'h55, 1'b1},
        '{8'hAA, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'hAA, 1'b1, 1'b1, 1'b1, 8'h00, 8'hAA, 1'b1},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h02, 1'b1, 1'b1, 1'b1, 8'h01, 8'h02, 1'b1},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
        '{8'h7F, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}
    };

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 sym_valid  = 1'b0;
    logic                 sym_ready;
    lz78c_pkg::in_item_t  sym_data   = '0;
    logic                 pair_valid;
    logic                 pair_ready = 1'b0;
    lz78c_pkg::out_item_t pair_data;

    lz78c_pkg::index_t    dict_parent [1:lz78c_pkg::DICT_SIZE];
    lz78c_pkg::sym_t      dict_symbol [1:lz78c_pkg::DICT_SIZE];
    int                   dict_count = 0;
    lz78c_pkg::index_t    cur_prefix = '0;

    lz78c_pkg::out_item_t expected_pairs [$];
    lz78c_pkg::out_item_t oldest_pair;

    int send_idle_pct  = 10;
    int recv_stall_pct = 51;
    int quiet_cycles   = 0;
    int errors         = 0;
    int bytes_sent     = 0;
    int pairs_checked  = 0;
    int streams_done   = 0;
    int flushed_hits   = 0;
    int full_misses    = 0;
    int max_prefix     = 0;

    always #2 clk = ~clk;

    lz78_byte_compressor_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .sym_data   (sym_data),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair_data  (pair_data)
    );

    // dictionary model: returns 1 when the byte produces a pair
    function automatic bit compress_byte(input lz78c_pkg::in_item_t it,
                                         output lz78c_pkg::out_item_t pair);
        lz78c_pkg::index_t hit;
        hit  = '0;
        pair = '0;
        for (int k = 1; k <= dict_count; k++)
        begin
            if (hit == '0 && dict_parent[k] == cur_prefix && dict_symbol[k] == it.symbol)
            begin
                hit = lz78c_pkg::index_t'(k);
            end
        end
        if (hit != '0 && !it.last)
        begin
            cur_prefix = hit;
            return 1'b0;
        end
        if (hit != '0)
        begin
            flushed_hits++;
        end
        pair.prefix_index = cur_prefix;
        pair.new_symbol   = it.symbol;
        pair.stream_end   = it.last;
        if (int'(cur_prefix) > max_prefix)
        begin
            max_prefix = int'(cur_prefix);
        end
        if (hit == '0 && dict_count < lz78c_pkg::DICT_SIZE)
        begin
            dict_count++;
            dict_parent[dict_count] = cur_prefix;
            dict_symbol[dict_count] = it.symbol;
        end
        else if (hit == '0)
        begin
            full_misses++;
        end
        cur_prefix = '0;
        if (it.last)
        begin
            dict_count = 0;
            streams_done++;
        end
        return 1'b1;
    endfunction

    function automatic lz78c_pkg::in_item_t make_byte(input lz78c_pkg::sym_t s,
                                                      input logic l);
        lz78c_pkg::in_item_t it;
        it.symbol = s;
        it.last   = l;
        return it;
    endfunction

    task automatic send_byte(input lz78c_pkg::in_item_t it, input bit typed,
                             input bit typed_has, input lz78c_pkg::out_item_t typed_pair);
        lz78c_pkg::out_item_t pred;
        bit                   has;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            sym_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        sym_valid <= 1'b1;
        sym_data  <= it;
        do @(posedge clk); while (!sym_ready);
        has = compress_byte(it, pred);
        if (typed)
        begin
            has  = typed_has;
            pred = typed_pair;
        end
        if (has)
        begin
            expected_pairs.push_back(pred);
        end
        bytes_sent++;
    endtask

    // small alphabets give long matches, wide ones mostly misses
    task automatic send_stream(input int len, input bit narrow);
        lz78c_pkg::sym_t alphabet [4];
        int              n_sym;
        lz78c_pkg::sym_t s;
        n_sym = $urandom_range(1, 4);
        for (int a = 0; a < 4; a++)
        begin
            alphabet[a] = lz78c_pkg::sym_t'($urandom);
        end
        for (int i = 0; i < len; i++)
        begin
            s = narrow ? alphabet[$urandom_range(n_sym - 1)] : lz78c_pkg::sym_t'($urandom);
            send_byte(make_byte(s, i == len - 1), 1'b0, 1'b0, '0);
        end
    endtask

    task automatic report_field(input string field, input int unsigned exp_val,
                                input int unsigned got_val);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%0t: %s expected %0h got %0h", $time, field, exp_val, got_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair_valid && pair_ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    report_field("pair with none pending, prefix_index", 0,
                                 pair_data.prefix_index);
                end
                else
                begin
                    oldest_pair = expected_pairs.pop_front();
                    pairs_checked++;
                    if (pair_data.prefix_index !== oldest_pair.prefix_index)
                    begin
                        report_field("prefix_index", oldest_pair.prefix_index,
                                     pair_data.prefix_index);
                    end
                    if (pair_data.new_symbol !== oldest_pair.new_symbol)
                    begin
                        report_field("new_symbol", oldest_pair.new_symbol,
                                     pair_data.new_symbol);
                    end
                    if (pair_data.stream_end !== oldest_pair.stream_end)
                    begin
                        report_field("stream_end", oldest_pair.stream_end,
                                     pair_data.stream_end);
                    end
                end
            end
            pair_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sym_valid && sym_ready) || (pair_valid && pair_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int                   phase_start;
        int                   len;
        lz78c_pkg::out_item_t row_pair;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row_pair.prefix_index = directed_rows[r].exp_prefix;
            row_pair.new_symbol   = directed_rows[r].exp_symbol;
            row_pair.stream_end   = directed_rows[r].exp_end;
            send_byte(make_byte(directed_rows[r].symbol, directed_rows[r].last),
                      directed_rows[r].typed, directed_rows[r].has_pair, row_pair);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 51 : 0;
            recv_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 10 : 0;
            if (ph == 2)
            begin
                // fill the dictionary, overflow it, then match the top entry
                for (int b = 0; b < 256; b++)
                begin
                    send_byte(make_byte(lz78c_pkg::sym_t'(b), 1'b0), 1'b0, 1'b0, '0);
                end
                send_byte(make_byte(8'hFF, 1'b0), 1'b0, 1'b0, '0);
                send_byte(make_byte(8'hFE, 1'b0), 1'b0, 1'b0, '0);
                send_byte(make_byte(8'h00, 1'b0), 1'b0, 1'b0, '0);
                send_byte(make_byte(8'h05, 1'b0), 1'b0, 1'b0, '0);
                send_byte(make_byte(8'h03, 1'b1), 1'b0, 1'b0, '0);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                len = ($urandom_range(99) < 10) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 30);
                send_stream(len, $urandom_range(99) < 85);
            end
        end
        sym_valid <= 1'b0;

        while (expected_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d streams, %0d pairs checked", bytes_sent, streams_done,
                 pairs_checked);
        $display("%0d matches flushed at stream end, %0d misses on a full dictionary, %s %0d",
                 flushed_hits, full_misses, "highest prefix index", max_prefix);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== lz78_byte_compressor_core.f =====
design/lz78c_pkg.sv
design/lz78c_cell.sv
design/lz78c_cell_row.sv
design/lz78c_top_ctrl.sv
design/lz78_byte_compressor_core.sv
bench/tb_lz78_byte_compressor_core.sv
